@@ hw/rtl/chht_pkg.sv @@
// Shared types and constants of the colour histogram hash table.
// Payload structs, configuration register layout and hash weights.
// No dependencies.
package chht_pkg;

  // Fixed field widths
  localparam int unsigned SAMPLE_W = 16;
  localparam int unsigned KEY_W    = 64;
  localparam int unsigned COUNT_W  = 32;
  localparam int unsigned CFG_DW   = 16;

  // Hash weights: w_c = HASH_W0 + HASH_WSTEP * c
  localparam int unsigned HASH_W0    = 30013;
  localparam int unsigned HASH_WSTEP = 418;
  localparam int unsigned WEIGHT_W   = 15;

  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

  // Operation codes
  localparam logic OP_ADD   = 1'b0;
  localparam logic OP_CLEAR = 1'b1;

  // Configuration register indexes
  typedef enum logic [1:0] {
    CFG_CHANNELS   = 2'd0,
    CFG_MAX_SAMPLE = 2'd1,
    CFG_MAX_COLORS = 2'd2
  } cfg_idx_e;

  // Reset values of the configuration registers
  localparam logic [2:0]  RST_CHANNELS   = 3'd3;
  localparam logic [15:0] RST_MAX_SAMPLE = 16'd255;
  localparam logic [10:0] RST_MAX_COLORS = 11'd256;

  typedef struct packed {
    logic [2:0]  channels;
    logic [15:0] max_sample;
    logic [10:0] max_colors;
  } cfg_t;

  typedef struct packed {
    logic        op;
    logic [15:0] chan0_value;
    logic [15:0] chan1_value;
    logic [15:0] chan2_value;
    logic [15:0] chan3_value;
    logic        last_pixel;
  } in_item_t;

  typedef struct packed {
    logic [14:0] bucket;
    logic [31:0] pixel_count;
    logic        new_color;
    logic [10:0] distinct_colors;
    logic        table_full;
    logic        bad_sample;
    logic        image_done;
  } out_item_t;

endpackage

@@ hw/rtl/color_histogram_hash_table.sv @@
// Colour histogram in a chained hash table. One pixel transaction at a time: an add goes
// through acceptance, the multiply-accumulate of the samples, the mod BUCKETS reduction,
// the bucket hand-over, head read, a chain walk through the entry memory's single read
// port, update, three entry write-back slots and the result hand-off; appending a new
// colour adds the miss state before the update, and a miss on a full table skips the
// update and write-backs. A clear sweeps the bucket head memory one entry a cycle.
// After reset the same sweep runs with in_stall_o high; configuration writes are taken
// throughout. A finished result sits in the output register so the next pixel can be
// taken meanwhile.
// Depends on chht_pkg and chht_engine.
module color_histogram_hash_table #(
  parameter int unsigned BUCKETS      = 20023,
  parameter int unsigned MAX_ENTRIES  = 1024,
  parameter int unsigned MAX_CHANNELS = 4
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [1:0]          cfg_idx_i,
  input  logic [chht_pkg::CFG_DW-1:0] cfg_wdata_i,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  chht_pkg::in_item_t  in_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output chht_pkg::out_item_t out_o
);
  import chht_pkg::*;

  cfg_t      cfg_q;
  logic      eng_ready, res_valid, res_load;
  out_item_t res;
  logic      out_valid_q, out_valid_d;
  out_item_t out_q;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.channels   <= RST_CHANNELS;
      cfg_q.max_sample <= RST_MAX_SAMPLE;
      cfg_q.max_colors <= RST_MAX_COLORS;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_CHANNELS:   cfg_q.channels   <= cfg_wdata_i[2:0];
        CFG_MAX_SAMPLE: cfg_q.max_sample <= cfg_wdata_i;
        CFG_MAX_COLORS: cfg_q.max_colors <= cfg_wdata_i[10:0];
        default: ;
      endcase
    end
  end

  chht_engine #(
    .BUCKETS      (BUCKETS),
    .MAX_ENTRIES  (MAX_ENTRIES),
    .MAX_CHANNELS (MAX_CHANNELS)
  ) u_engine (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .start_i     (in_valid_i && eng_ready),
    .item_i      (in_i),
    .ready_o     (eng_ready),
    .res_valid_o (res_valid),
    .res_ready_i (res_load),
    .res_o       (res)
  );

  assign in_stall_o = !eng_ready;

  // Output register
  assign res_load = res_valid && (!out_valid_q || !out_stall_i);

  always_comb begin
    if (res_load) out_valid_d = 1'b1;
    else if (out_stall_i) out_valid_d = out_valid_q;
    else out_valid_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_load) out_q <= res;
  end

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

endmodule

@@ hw/rtl/chht_hash.sv @@
// Colour hash unit: weighted sum of the samples, XOR fold, reduction mod BUCKETS.
// Per channel a multiply step then an add step; then four remainder bits a cycle.
// Depends on chht_pkg.
module chht_hash #(
  parameter int unsigned BUCKETS      = 20023,
  parameter int unsigned MAX_CHANNELS = 4,
  localparam int unsigned HW = (BUCKETS > 1) ? $clog2(BUCKETS) : 1
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic [chht_pkg::KEY_W-1:0]   key_i,
  output logic                         done_o,
  output logic [HW-1:0]                bucket_o
);
  import chht_pkg::*;

  localparam int unsigned CW        = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
  localparam int unsigned RW        = HW + 1;
  localparam int unsigned MOD_BITS  = 4;
  localparam int unsigned MOD_STEPS = 32 / MOD_BITS;
  localparam int unsigned SW        = $clog2(MOD_STEPS);

  typedef enum logic [3:0] {
    H_IDLE = 4'b0001,
    H_MUL  = 4'b0010,
    H_ADD  = 4'b0100,
    H_MOD  = 4'b1000
  } hash_state_e;

  hash_state_e         state_q, state_d;
  logic [KEY_W-1:0]    key_q;
  logic [CW-1:0]       ch_q;
  logic [30:0]         prod_q;
  logic [33:0]         acc_q;
  logic [33:0]         acc_n;
  logic [31:0]         word_q, word_n;
  logic [RW-1:0]       rem_q, rem_n;
  logic [SW-1:0]       step_q;
  logic                done_q;
  logic [HW-1:0]       bucket_q;
  logic [WEIGHT_W-1:0] weight;
  logic [SAMPLE_W-1:0] sample;

  // Weight and sample of the current channel
  assign weight = WEIGHT_W'(HASH_W0 + HASH_WSTEP * int'(ch_q));
  assign sample = key_q[SAMPLE_W*ch_q +: SAMPLE_W];
  assign acc_n  = acc_q + 34'(prod_q);

  // Restoring remainder, four dividend bits per cycle
  always_comb begin
    logic [RW-1:0] r;
    logic [31:0]   w;
    r = rem_q;
    w = word_q;
    for (int i = 0; i < MOD_BITS; i++) begin
      r = {r[HW-1:0], w[31]};
      w = {w[30:0], 1'b0};
      if (r >= RW'(BUCKETS)) begin
        r = r - RW'(BUCKETS);
      end
    end
    rem_n  = r;
    word_n = w;
  end

  // Sequencer
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      H_IDLE: if (start_i) state_d = H_MUL;
      H_MUL:  state_d = H_ADD;
      H_ADD:  state_d = (ch_q == CW'(MAX_CHANNELS - 1)) ? H_MOD : H_MUL;
      H_MOD:  if (step_q == SW'(MOD_STEPS - 1)) state_d = H_IDLE;
      default: state_d = H_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= H_IDLE;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= (state_q == H_MOD) && (step_q == SW'(MOD_STEPS - 1));
    end
  end

  // Datapath
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      H_IDLE: begin
        key_q  <= key_i;
        ch_q   <= '0;
        acc_q  <= '0;
        rem_q  <= '0;
        step_q <= '0;
      end
      H_MUL: prod_q <= 31'(weight) * 31'(sample);
      H_ADD: begin
        acc_q  <= acc_n;
        ch_q   <= ch_q + CW'(1);
        word_q <= acc_n[31:0] ^ 32'(acc_n[33:32]);
      end
      H_MOD: begin
        rem_q  <= rem_n;
        word_q <= word_n;
        step_q <= step_q + SW'(1);
        if (step_q == SW'(MOD_STEPS - 1)) bucket_q <= rem_n[HW-1:0];
      end
      default: ;
    endcase
  end

  assign done_o   = done_q;
  assign bucket_o = bucket_q;

endmodule

@@ hw/rtl/chht_engine.sv @@
// Table engine: bucket head memory, entry memory and the chain walk sequencer.
// Reads, updates and writes back entries one transaction at a time.
// Depends on chht_pkg and chht_hash.
module chht_engine #(
  parameter int unsigned BUCKETS      = 20023,
  parameter int unsigned MAX_ENTRIES  = 1024,
  parameter int unsigned MAX_CHANNELS = 4
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  chht_pkg::cfg_t       cfg_i,
  input  logic                 start_i,
  input  chht_pkg::in_item_t   item_i,
  output logic                 ready_o,
  output logic                 res_valid_o,
  input  logic                 res_ready_i,
  output chht_pkg::out_item_t  res_o
);
  import chht_pkg::*;

  localparam int unsigned HW = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
  localparam int unsigned LW = $clog2(MAX_ENTRIES + 1);
  localparam int unsigned AW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam logic [LW-1:0] NIL = LW'(MAX_ENTRIES);

  typedef struct packed {
    logic [KEY_W-1:0]   color;
    logic [COUNT_W-1:0] count;
    logic [LW-1:0]      next;
  } ent_t;

  typedef enum logic [10:0] {
    E_CLR   = 11'b000_0000_0001,
    E_IDLE  = 11'b000_0000_0010,
    E_HASH  = 11'b000_0000_0100,
    E_HEAD  = 11'b000_0000_1000,
    E_WALK  = 11'b000_0001_0000,
    E_MISS  = 11'b000_0010_0000,
    E_UPD   = 11'b000_0100_0000,
    E_WCUR  = 11'b000_1000_0000,
    E_WPREV = 11'b001_0000_0000,
    E_WPP   = 11'b010_0000_0000,
    E_DONE  = 11'b100_0000_0000
  } eng_state_e;

  // Memories
  logic [LW-1:0] head_mem [BUCKETS];
  ent_t          ent_mem  [MAX_ENTRIES];

  eng_state_e         state_q;
  logic [HW-1:0]      ptr_q;
  logic               clr_pend_q;
  logic [LW-1:0]      used_q;
  logic               ovf_q;
  logic [KEY_W-1:0]   key_q, key_d;
  logic               bad_q, bad_d;
  logic               last_q;
  logic [HW-1:0]      h_q;
  logic [COUNT_W-1:0] cnt_q;
  logic               isnew_q;
  logic [LW-1:0]      cur_q, prev_q, pprev_q;
  ent_t               cur_ent_q, prev_ent_q, pprev_ent_q;
  logic [LW-1:0]      steps_q;
  logic               head_dirty_q;
  logic [LW-1:0]      head_val_q;

  logic               hash_done;
  logic [HW-1:0]      hash_bucket;

  logic               head_re, head_we;
  logic [HW-1:0]      head_ra, head_wa;
  logic [LW-1:0]      head_wd, head_rd_q;
  logic               ent_re, ent_we;
  logic [AW-1:0]      ent_ra, ent_wa;
  ent_t               ent_wd, ent_rd_q;

  logic               hit, walk_more, room;
  logic [COUNT_W-1:0] cnt_inc;
  logic [2:0]         nch;
  logic [SAMPLE_W-1:0] smp [4];

  // Key and range check of an incoming pixel
  assign smp[0] = item_i.chan0_value;
  assign smp[1] = item_i.chan1_value;
  assign smp[2] = item_i.chan2_value;
  assign smp[3] = item_i.chan3_value;

  always_comb begin
    if (cfg_i.channels == 3'd0) begin
      nch = 3'd1;
    end else if (32'(cfg_i.channels) > MAX_CHANNELS) begin
      nch = 3'(MAX_CHANNELS);
    end else begin
      nch = cfg_i.channels;
    end
    key_d = '0;
    bad_d = 1'b0;
    for (int c = 0; c < 4; c++) begin
      if (c < int'(nch)) begin
        key_d[SAMPLE_W*c +: SAMPLE_W] = smp[c];
        if (smp[c] > cfg_i.max_sample) bad_d = 1'b1;
      end
    end
  end

  chht_hash #(
    .BUCKETS      (BUCKETS),
    .MAX_CHANNELS (MAX_CHANNELS)
  ) u_hash (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (state_q == E_IDLE && start_i && item_i.op == OP_ADD),
    .key_i    (key_d),
    .done_o   (hash_done),
    .bucket_o (hash_bucket)
  );

  // Walk decisions
  assign hit       = (ent_rd_q.color == key_q);
  assign walk_more = !hit && (ent_rd_q.next < NIL)
                     && (32'(steps_q) + 32'd1 < MAX_ENTRIES);
  assign room      = (32'(used_q) < 32'(cfg_i.max_colors)) && (32'(used_q) < MAX_ENTRIES);
  assign cnt_inc   = (cur_ent_q.count == COUNT_MAX) ? cur_ent_q.count
                                                    : cur_ent_q.count + COUNT_W'(1);

  // Memory port control
  always_comb begin
    head_re = (state_q == E_HASH) && hash_done;
    head_ra = hash_bucket;
    head_we = 1'b0;
    head_wa = h_q;
    head_wd = head_val_q;
    ent_re  = 1'b0;
    ent_ra  = head_rd_q[AW-1:0];
    ent_we  = 1'b0;
    ent_wa  = cur_q[AW-1:0];
    ent_wd  = cur_ent_q;
    unique case (state_q)
      E_CLR: begin
        head_we = 1'b1;
        head_wa = ptr_q;
        head_wd = NIL;
      end
      E_HEAD: ent_re = (head_rd_q < NIL);
      E_WALK: begin
        ent_re = walk_more;
        ent_ra = ent_rd_q.next[AW-1:0];
      end
      E_WCUR: begin
        ent_we  = 1'b1;
        head_we = head_dirty_q;
      end
      E_WPREV: begin
        ent_we = (prev_q != NIL);
        ent_wa = prev_q[AW-1:0];
        ent_wd = prev_ent_q;
      end
      E_WPP: begin
        ent_we = (pprev_q != NIL);
        ent_wa = pprev_q[AW-1:0];
        ent_wd = pprev_ent_q;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (head_we) head_mem[head_wa] <= head_wd;
    if (head_re) head_rd_q <= head_mem[head_ra];
  end

  always_ff @(posedge clk_i) begin
    if (ent_we) ent_mem[ent_wa] <= ent_wd;
    if (ent_re) ent_rd_q <= ent_mem[ent_ra];
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= E_CLR;
      ptr_q      <= '0;
      clr_pend_q <= 1'b0;
      used_q     <= '0;
      ovf_q      <= 1'b0;
    end else begin
      unique case (state_q)
        E_CLR: begin
          ptr_q <= ptr_q + HW'(1);
          if (ptr_q == HW'(BUCKETS - 1)) begin
            state_q <= clr_pend_q ? E_DONE : E_IDLE;
          end
        end
        E_IDLE: if (start_i) begin
          if (item_i.op == OP_CLEAR) begin
            used_q     <= '0;
            ovf_q      <= 1'b0;
            ptr_q      <= '0;
            clr_pend_q <= 1'b1;
            state_q    <= E_CLR;
          end else begin
            state_q <= E_HASH;
          end
        end
        E_HASH: if (hash_done) state_q <= E_HEAD;
        E_HEAD: state_q <= (head_rd_q < NIL) ? E_WALK : E_MISS;
        E_WALK: begin
          if (hit) state_q <= E_UPD;
          else if (!walk_more) state_q <= E_MISS;
        end
        E_MISS: begin
          if (room) begin
            used_q  <= used_q + LW'(1);
            state_q <= E_UPD;
          end else begin
            ovf_q   <= 1'b1;
            state_q <= E_DONE;
          end
        end
        E_UPD:   state_q <= E_WCUR;
        E_WCUR:  state_q <= E_WPREV;
        E_WPREV: state_q <= E_WPP;
        E_WPP:   state_q <= E_DONE;
        E_DONE: if (res_ready_i) begin
          clr_pend_q <= 1'b0;
          state_q    <= E_IDLE;
        end
        default: state_q <= E_IDLE;
      endcase
    end
  end

  // Transaction datapath
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      E_IDLE: if (start_i) begin
        key_q   <= key_d;
        bad_q   <= (item_i.op == OP_CLEAR) ? 1'b0 : bad_d;
        last_q  <= item_i.last_pixel;
        h_q     <= '0;
        cnt_q   <= '0;
        isnew_q <= 1'b0;
      end
      E_HASH: h_q <= hash_bucket;
      E_HEAD: begin
        cur_q        <= head_rd_q;
        prev_q       <= NIL;
        pprev_q      <= NIL;
        steps_q      <= '0;
        head_dirty_q <= 1'b0;
      end
      E_WALK: begin
        if (hit) begin
          cur_ent_q <= ent_rd_q;
        end else begin
          pprev_q     <= prev_q;
          pprev_ent_q <= prev_ent_q;
          prev_q      <= cur_q;
          prev_ent_q  <= ent_rd_q;
          cur_q       <= ent_rd_q.next;
          steps_q     <= steps_q + LW'(1);
        end
      end
      E_MISS: if (room) begin
        cur_q           <= used_q;
        cur_ent_q.color <= key_q;
        cur_ent_q.count <= '0;
        cur_ent_q.next  <= NIL;
        isnew_q         <= 1'b1;
        if (prev_q == NIL) begin
          head_dirty_q <= 1'b1;
          head_val_q   <= used_q;
        end else begin
          prev_ent_q.next <= used_q;
        end
      end
      E_UPD: begin
        cur_ent_q.count <= cnt_inc;
        cnt_q           <= cnt_inc;
        // Move ahead of the predecessor once this count passes it
        if (prev_q != NIL && cnt_inc > prev_ent_q.count) begin
          if (pprev_q == NIL) begin
            head_dirty_q <= 1'b1;
            head_val_q   <= cur_q;
          end else begin
            pprev_ent_q.next <= cur_q;
          end
          prev_ent_q.next <= cur_ent_q.next;
          cur_ent_q.next  <= prev_q;
        end
      end
      default: ;
    endcase
  end

  assign ready_o     = (state_q == E_IDLE);
  assign res_valid_o = (state_q == E_DONE);

  always_comb begin
    res_o.bucket          = 15'(32'(h_q));
    res_o.pixel_count     = cnt_q;
    res_o.new_color       = isnew_q;
    res_o.distinct_colors = 11'(32'(used_q));
    res_o.table_full      = ovf_q;
    res_o.bad_sample      = bad_q;
    res_o.image_done      = last_q;
  end

endmodule

@@ hw/rtl/chht_checker.sv @@
// Port-level checks of the colour histogram hash table, and their bind.
// Depends on chht_pkg and color_histogram_hash_table.
module chht_checker #(
  parameter int unsigned BUCKETS     = 20023,
  parameter int unsigned MAX_ENTRIES = 1024
) (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                out_valid_o,
  input logic                out_stall_i,
  input chht_pkg::out_item_t out_o
);
  import chht_pkg::*;

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_o))
    else $error("result changed while stalled");

  // A new colour starts at a count of one
  a_new_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_o.new_color |-> out_o.pixel_count == 32'd1
                                       && out_o.distinct_colors != 11'd0)
    else $error("new colour with wrong count");

  // A zero count without overflow is a clear transaction
  a_clear_res: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_o.pixel_count == 32'd0 && !out_o.table_full |->
      out_o.bucket == 15'd0 && out_o.distinct_colors == 11'd0
      && !out_o.new_color && !out_o.bad_sample)
    else $error("clear result not zero");

  // Bucket and colour count stay in range
  a_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> 32'(out_o.bucket) < BUCKETS
                    && 32'(out_o.distinct_colors) <= MAX_ENTRIES)
    else $error("result out of range");

endmodule

bind color_histogram_hash_table chht_checker #(
  .BUCKETS     (BUCKETS),
  .MAX_ENTRIES (MAX_ENTRIES)
) u_chht_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_o       (out_o)
);

@@ test/color_histogram_hash_table_checker.sv @@
`timescale 1ns / 1ps
// Checker for the colour histogram hash table: watches the configuration port and both
// channels, predicts every result from its own copy of the table and compares.
// Depends on chht_pkg.
module color_histogram_hash_table_checker
  import chht_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [1:0]          cfg_idx_i,
  input  logic [CFG_DW-1:0]   cfg_wdata_i,
  input  logic                in_valid_i,
  input  logic                in_stall_i,
  input  in_item_t            in_i,
  input  logic                out_valid_i,
  input  logic                out_stall_i,
  input  out_item_t           out_i,
  output int                  fail_count_o,
  output int                  pending_o,
  output int                  checked_o
);

  localparam int unsigned NUM_BUCKETS = 20023;
  localparam int unsigned NUM_SLOTS   = 1024;
  localparam int unsigned NO_LINK     = NUM_SLOTS;

  // Mirror of the block's table
  int unsigned     chain_head [NUM_BUCKETS];
  logic [KEY_W-1:0] slot_color [NUM_SLOTS];
  int unsigned     slot_count [NUM_SLOTS];
  int unsigned     slot_link  [NUM_SLOTS];
  int unsigned     slots_used;
  bit              overflowed;

  // Mirror of the registers
  logic [2:0]  reg_channels;
  logic [15:0] reg_max_sample;
  logic [10:0] reg_max_colors;

  out_item_t expected_results[$];

  int fails;
  int checked;
  assign fail_count_o = fails;
  assign pending_o    = expected_results.size();
  assign checked_o    = checked;

  task automatic empty_table();
    for (int i = 0; i < NUM_BUCKETS; i++) chain_head[i] = NO_LINK;
    slots_used = 0;
    overflowed = 0;
  endtask

  // Histogram update for one pixel transaction
  task automatic count_pixel(input in_item_t px, output out_item_t res);
    int unsigned     smp [4];
    int unsigned     nch, lim, h, cur, prv, pprv, steps;
    logic [63:0]     acc;
    logic [31:0]     folded;
    logic [KEY_W-1:0] key;
    bit              bad, fresh;
    int unsigned     cnt;
    res = '0;
    res.image_done = px.last_pixel;
    if (px.op == OP_CLEAR) begin
      empty_table();
      return;
    end
    smp[0] = 32'(px.chan0_value);
    smp[1] = 32'(px.chan1_value);
    smp[2] = 32'(px.chan2_value);
    smp[3] = 32'(px.chan3_value);
    nch = 32'(reg_channels);
    if (nch == 0) nch = 1;
    if (nch > 4) nch = 4;
    bad = 0;
    key = '0;
    acc = '0;
    for (int c = 0; c < 4; c++) if (c >= nch) smp[c] = 0;
    for (int c = 0; c < nch; c++) begin
      if (smp[c] > 32'(reg_max_sample)) bad = 1;
      key[16*c +: 16] = smp[c][15:0];
      acc += 64'((HASH_W0 + HASH_WSTEP * c) * smp[c]);
    end
    folded = acc[31:0] ^ acc[63:32];
    h = folded % NUM_BUCKETS;
    lim = (32'(reg_max_colors) > NUM_SLOTS) ? NUM_SLOTS : 32'(reg_max_colors);

    // Walk the chain looking for the colour
    cur = chain_head[h];
    prv = NO_LINK;
    pprv = NO_LINK;
    steps = 0;
    while (cur < NO_LINK && steps < NUM_SLOTS) begin
      if (slot_color[cur] == key) break;
      pprv = prv;
      prv = cur;
      cur = slot_link[cur];
      steps++;
    end
    if (cur >= NO_LINK) cur = NO_LINK;

    // Miss: append at the tail if there is room
    fresh = 0;
    if (cur == NO_LINK) begin
      if (slots_used < lim) begin
        cur = slots_used;
        slot_color[cur] = key;
        slot_count[cur] = 0;
        slot_link[cur] = NO_LINK;
        if (prv == NO_LINK) chain_head[h] = cur;
        else slot_link[prv] = cur;
        slots_used++;
        fresh = 1;
      end else begin
        overflowed = 1;
      end
    end

    // Count, then move ahead of the predecessor when it overtakes it
    cnt = 0;
    if (cur != NO_LINK) begin
      if (slot_count[cur] != 32'hFFFF_FFFF) slot_count[cur]++;
      cnt = slot_count[cur];
      if (prv != NO_LINK && cnt > slot_count[prv]) begin
        if (pprv == NO_LINK) chain_head[h] = cur;
        else slot_link[pprv] = cur;
        slot_link[prv] = slot_link[cur];
        slot_link[cur] = prv;
      end
    end

    res.bucket          = h[14:0];
    res.pixel_count     = cnt;
    res.new_color       = fresh;
    res.distinct_colors = slots_used[10:0];
    res.table_full      = overflowed;
    res.bad_sample      = bad;
  endtask

  task automatic report_mismatch(input string field, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("result %0d: %s is %0d, expected %0d", checked, field, got, want);
    fails++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    out_item_t want;
    out_item_t got;
    if (!rst_ni) begin
      empty_table();
      reg_channels   = RST_CHANNELS;
      reg_max_sample = RST_MAX_SAMPLE;
      reg_max_colors = RST_MAX_COLORS;
      expected_results.delete();
      fails   = 0;
      checked = 0;
    end else begin
      // register writes
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_CHANNELS:   reg_channels   = cfg_wdata_i[2:0];
          CFG_MAX_SAMPLE: reg_max_sample = cfg_wdata_i[15:0];
          CFG_MAX_COLORS: reg_max_colors = cfg_wdata_i[10:0];
          default: ;
        endcase
      end
      // accepted pixel transaction
      if (in_valid_i && !in_stall_i) begin
        count_pixel(in_i, want);
        expected_results.push_back(want);
      end
      // accepted result transaction
      if (out_valid_i && !out_stall_i) begin
        got = out_i;
        if (expected_results.size() == 0) begin
          report_mismatch("unexpected result", 32'd1, 32'd0);
        end else begin
          want = expected_results.pop_front();
          if (got.bucket != want.bucket)
            report_mismatch("bucket", 32'(got.bucket), 32'(want.bucket));
          if (got.pixel_count != want.pixel_count)
            report_mismatch("pixel_count", got.pixel_count, want.pixel_count);
          if (got.new_color != want.new_color)
            report_mismatch("new_color", 32'(got.new_color), 32'(want.new_color));
          if (got.distinct_colors != want.distinct_colors)
            report_mismatch("distinct_colors", 32'(got.distinct_colors),
                            32'(want.distinct_colors));
          if (got.table_full != want.table_full)
            report_mismatch("table_full", 32'(got.table_full), 32'(want.table_full));
          if (got.bad_sample != want.bad_sample)
            report_mismatch("bad_sample", 32'(got.bad_sample), 32'(want.bad_sample));
          if (got.image_done != want.image_done)
            report_mismatch("image_done", 32'(got.image_done), 32'(want.image_done));
        end
        checked++;
      end
    end
  end

endmodule

@@ test/color_histogram_hash_table_tb.sv @@
`timescale 1ns / 1ps
// Testbench top for the colour histogram hash table: clock, reset, pixel stimulus,
// register settings, output stalls and the verdict.
// Depends on chht_pkg, color_histogram_hash_table and its checker.
module color_histogram_hash_table_tb;
  import chht_pkg::*;

  localparam int CYCLE_LIMIT = 3_000_000;
  localparam int SETTLE      = 64;
  localparam int HOLD_CYCLES = 400;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              cfg_we_i = 1'b0;
  logic [1:0]        cfg_idx_i = CFG_CHANNELS;
  logic [CFG_DW-1:0] cfg_wdata_i = '0;
  logic              in_valid_i = 1'b0;
  logic              in_stall_o;
  in_item_t          in_i = '0;
  logic              out_valid_o;
  logic              out_stall_i = 1'b0;
  out_item_t         out_o;

  int fail_count, pending, checked;
  int send_idle_pct, recv_idle_pct;
  int hold_req = 0;
  int hold_seen = 0;
  int hold_left = 0;
  int cycles = 0;
  int pixels_sent, clears_sent;

  // 16-colour palette of the current image
  in_item_t palette[16];

  color_histogram_hash_table dut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_wdata_i,
    .in_valid_i, .in_stall_o, .in_i, .out_valid_o, .out_stall_i, .out_o
  );

  color_histogram_hash_table_checker checker_i (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_wdata_i,
    .in_valid_i, .in_stall_i(in_stall_o), .in_i,
    .out_valid_i(out_valid_o), .out_stall_i, .out_i(out_o),
    .fail_count_o(fail_count), .pending_o(pending), .checked_o(checked)
  );

  always #5 clk_i = ~clk_i;

  // Watchdog
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("color_histogram_hash_table: mismatch");
      $finish;
    end
  end

  // Receiver: random stalls, or a long hold-off when one is requested
  always @(posedge clk_i) begin
    if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_stall_i <= 1'b1;
    end else if (hold_seen != hold_req) begin
      hold_seen <= hold_req;
      hold_left <= HOLD_CYCLES;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= ($urandom_range(0, 99) < recv_idle_pct);
    end
  end

  // Offer one pixel transaction, with random gaps before it
  task automatic send_pixel(input in_item_t px);
    if (send_idle_pct > 0 && $urandom_range(0, 99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(0, 99) < send_idle_pct);
    end
    in_valid_i <= 1'b1;
    in_i <= px;
    do @(posedge clk_i); while (in_stall_o);
    if (px.op == OP_CLEAR) clears_sent++;
    else pixels_sent++;
  endtask

  // Stop offering and wait until every result is back and the block has settled
  task automatic drain();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic set_regs(input logic [2:0] ch, input logic [15:0] ms,
                          input logic [10:0] mc);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= CFG_CHANNELS;
    cfg_wdata_i <= 16'(ch);
    @(posedge clk_i);
    cfg_idx_i <= CFG_MAX_SAMPLE;
    cfg_wdata_i <= ms;
    @(posedge clk_i);
    cfg_idx_i <= CFG_MAX_COLORS;
    cfg_wdata_i <= 16'(mc);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  function automatic in_item_t make_pixel(input logic [15:0] c0, c1, c2, c3,
                                          input logic last);
    in_item_t px;
    px.op = OP_ADD;
    px.chan0_value = c0;
    px.chan1_value = c1;
    px.chan2_value = c2;
    px.chan3_value = c3;
    px.last_pixel = last;
    return px;
  endfunction

  function automatic in_item_t make_clear(input logic last);
    in_item_t px;
    px = in_item_t'($urandom()) ^ (in_item_t'($urandom()) << 32);
    px.op = OP_CLEAR;
    px.last_pixel = last;
    return px;
  endfunction

  // Groups of three colours that differ in channel 0 by the bucket count share a bucket,
  // so chains grow and reorder; the last four colours are anything at all
  task automatic new_palette();
    logic [15:0] b, o1, o2, o3;
    for (int g = 0; g < 4; g++) begin
      b  = 16'($urandom_range(0, 25488));
      o1 = 16'($urandom_range(0, 4095));
      o2 = 16'($urandom_range(0, 4095));
      o3 = 16'($urandom_range(0, 4095));
      for (int k = 0; k < 3; k++)
        palette[3*g + k] = make_pixel(b + 16'(20023 * k), o1, o2, o3, 1'b0);
    end
    for (int k = 12; k < 16; k++)
      palette[k] = make_pixel(16'($urandom()), 16'($urandom()), 16'($urandom()),
                              16'($urandom()), 1'b0);
  endtask

  task automatic random_phase(input int n_items);
    in_item_t px;
    int idx;
    for (int i = 0; i < n_items; i++) begin
      if (i % 80 == 79) begin
        send_pixel(make_clear(1'($urandom_range(0, 1))));
        new_palette();
      end else begin
        if ($urandom_range(0, 19) == 0) begin
          px = make_pixel(16'($urandom()), 16'($urandom()), 16'($urandom()),
                          16'($urandom()), 1'b0);
        end else begin
          // skewed pick so that later chain members overtake earlier ones
          idx = int'($urandom_range(0, 15));
          if ($urandom_range(0, 1) != 0) idx = idx % int'($urandom_range(1, 16));
          px = palette[idx];
        end
        px.last_pixel = ($urandom_range(0, 19) == 0);
        send_pixel(px);
      end
    end
  endtask

  initial begin
    logic [2:0]  ph_ch [8];
    logic [15:0] ph_ms [8];
    logic [10:0] ph_mc [8];
    ph_ch = '{3'd1, 3'd2, 3'd3, 3'd4, 3'd0, 3'd5, 3'd1, 3'd4};
    ph_ms = '{16'd255, 16'd65535, 16'd255, 16'd65535, 16'd1000, 16'd65535, 16'd1, 16'd255};
    ph_mc = '{11'd1024, 11'd8, 11'd256, 11'd1024, 11'd16, 11'd2047, 11'd3, 11'd0};
    pixels_sent = 0;
    clears_sent = 0;
    send_idle_pct = 0;
    recv_idle_pct = 0;

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: default registers, extreme samples, repeats
    send_pixel(make_pixel(16'h0, 16'h0, 16'h0, 16'h0, 1'b0));
    send_pixel(make_pixel(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0));
    send_pixel(make_pixel(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h1234, 1'b0));
    send_pixel(make_pixel(16'd100, 16'd200, 16'd255, 16'h5555, 1'b1));
    send_pixel(make_clear(1'b0));
    drain();

    // Channels zero acts as one; a shared bucket, then a swap up the chain
    set_regs(3'd0, 16'd1, 11'd2047);
    send_pixel(make_pixel(16'd5, 16'hAAAA, 16'h5555, 16'hFFFF, 1'b0));
    send_pixel(make_pixel(16'd20028, 16'h1, 16'h2, 16'h3, 1'b0));
    send_pixel(make_pixel(16'd40051, 16'h0, 16'h0, 16'h0, 1'b0));
    send_pixel(make_pixel(16'd40051, 16'h7, 16'h7, 16'h7, 1'b0));
    send_pixel(make_pixel(16'd40051, 16'h0, 16'h0, 16'h0, 1'b0));
    send_pixel(make_pixel(16'd0, 16'h0, 16'h0, 16'h0, 1'b0));
    send_pixel(make_clear(1'b1));
    drain();

    // Channels above the maximum, no room at all
    set_regs(3'd7, 16'd65535, 11'd0);
    send_pixel(make_pixel(16'h8001, 16'h4002, 16'h2004, 16'h1008, 1'b0));
    send_pixel(make_pixel(16'h0, 16'h0, 16'h0, 16'h0, 1'b1));
    drain();

    // Room for a single colour
    set_regs(3'd4, 16'd65535, 11'd1);
    send_pixel(make_pixel(16'h1111, 16'h2222, 16'h3333, 16'h4444, 1'b0));
    send_pixel(make_pixel(16'h1111, 16'h2222, 16'h3333, 16'h4445, 1'b0));
    send_pixel(make_pixel(16'h1111, 16'h2222, 16'h3333, 16'h4444, 1'b1));
    send_pixel(make_clear(1'b0));
    drain();

    // Random phases, each under its own register setting
    new_palette();
    for (int p = 0; p < 8; p++) begin
      set_regs(ph_ch[p], ph_ms[p], ph_mc[p]);
      if (p < 3) begin
        send_idle_pct = 19;
        recv_idle_pct = 75;
      end else if (p < 6) begin
        send_idle_pct = 75;
        recv_idle_pct = 19;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      if (p == 1 || p == 6) hold_req <= hold_req + 1;
      random_phase(160);
      drain();
    end

    $display("%0d pixels and %0d clears sent, %0d results checked",
             pixels_sent, clears_sent, checked);
    $display("eight register settings, shared buckets, overflow and long output hold-offs");
    if (fail_count == 0 && pending == 0) begin
      $display("color_histogram_hash_table: match");
    end else begin
      $display("color_histogram_hash_table: mismatch");
    end
    $finish;
  end

endmodule

@@ sim.f @@
hw/rtl/chht_pkg.sv
hw/rtl/chht_hash.sv
hw/rtl/chht_engine.sv
hw/rtl/color_histogram_hash_table.sv
hw/rtl/chht_checker.sv
test/color_histogram_hash_table_checker.sv
test/color_histogram_hash_table_tb.sv
